/* rtl/core/pmon_pkg.sv */
// ----------------------------------------------------------------------------
// pmon_pkg
// Shared types and constants for the three-phase peak voltage monitor.
// ----------------------------------------------------------------------------
package pmon_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int REG_W     = 10;
  localparam int REG_IDX_W = 3;
  localparam int PHASE_W   = 2;
  localparam int NUM_SRC   = 2;
  localparam int NUM_PHASE = 3;

  // RMS scaling: 5/1023 * 223.766 / 1.414 as unsigned Q0.16
  localparam int RMS_MUL_W = 16;
  localparam int PROD_W    = SAMPLE_W + RMS_MUL_W;
  localparam logic [RMS_MUL_W-1:0] RMS_MUL = 16'd50690;
  localparam int RMS_SHIFT = 16;

  localparam logic [REG_W-1:0] NOISE_FLOOR_RST = 10'd10;
  localparam logic [REG_W-1:0] LIMIT_RST       = 10'd180;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_NOISE_FLOOR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAINS_R     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAINS_Y     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAINS_B     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GEN_R       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GEN_Y       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GEN_B       = 3'd6;

  // Source and phase codes
  localparam logic SRC_MAINS = 1'b0;
  localparam logic SRC_GEN   = 1'b1;
  localparam logic [PHASE_W-1:0] PHASE_R = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_Y = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_B = 2'd2;

  typedef struct packed {
    logic [REG_W-1:0]                                noise_floor;
    logic [NUM_SRC-1:0][NUM_PHASE-1:0][REG_W-1:0]    limit;
  } cfg_t;

  // Closed window handed from the peak stage to the evaluation stage
  typedef struct packed {
    logic                source;
    logic [PHASE_W-1:0]  phase;
    logic [SAMPLE_W-1:0] peak;
  } win_t;

endpackage

/* rtl/core/pmon_cfg.sv */
// ----------------------------------------------------------------------------
// pmon_cfg
// Configuration registers: noise floor and six per-source, per-phase limits.
// ----------------------------------------------------------------------------
module pmon_cfg
  import pmon_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.noise_floor <= NOISE_FLOOR_RST;
      for (int s = 0; s < NUM_SRC; s++) begin
        for (int p = 0; p < NUM_PHASE; p++) begin
          regs.limit[s][p] <= LIMIT_RST;
        end
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOISE_FLOOR: regs.noise_floor  <= cfg_data;
        REG_MAINS_R:     regs.limit[0][0]  <= cfg_data;
        REG_MAINS_Y:     regs.limit[0][1]  <= cfg_data;
        REG_MAINS_B:     regs.limit[0][2]  <= cfg_data;
        REG_GEN_R:       regs.limit[1][0]  <= cfg_data;
        REG_GEN_Y:       regs.limit[1][1]  <= cfg_data;
        REG_GEN_B:       regs.limit[1][2]  <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* rtl/core/pmon_peak.sv */
// ----------------------------------------------------------------------------
// pmon_peak
// Input register, running maximum and window close register.
// ----------------------------------------------------------------------------
module pmon_peak
  import pmon_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_source,
  input  logic [PHASE_W-1:0]  in_phase,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last,
  input  logic                eval_free,
  output logic                win_valid,
  output win_t                win
);

  logic                in_v;
  logic                in_src;
  logic [PHASE_W-1:0]  in_ph;
  logic [SAMPLE_W-1:0] in_smp;
  logic                in_lst;
  logic [SAMPLE_W-1:0] running_peak;
  logic [SAMPLE_W-1:0] peak_next;
  logic                win_v;
  logic                win_en;
  logic                drain;

  assign win_en   = !win_v || eval_free;
  assign in_ready = !in_v || win_en;
  assign drain    = in_v && win_en;
  assign peak_next = (in_smp > running_peak) ? in_smp : running_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v         <= 1'b0;
      win_v        <= 1'b0;
      running_peak <= '0;
    end else begin
      if (in_ready) begin
        in_v <= in_valid;
      end
      if (win_en) begin
        win_v <= drain && in_lst;
      end
      if (drain) begin
        running_peak <= in_lst ? '0 : peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_src <= in_source;
      in_ph  <= in_phase;
      in_smp <= in_sample;
      in_lst <= in_last;
    end
    if (drain && in_lst) begin
      win.source <= in_src;
      win.phase  <= in_ph;
      win.peak   <= peak_next;
    end
  end

  assign win_valid = win_v;

endmodule

/* rtl/core/pmon_eval.sv */
// ----------------------------------------------------------------------------
// pmon_eval
// Noise floor, RMS scaling, limit check, per-source pass bits, result register.
// ----------------------------------------------------------------------------
module pmon_eval
  import pmon_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                win_valid,
  input  win_t                win,
  output logic                eval_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_source,
  output logic [PHASE_W-1:0]  out_phase,
  output logic [SAMPLE_W-1:0] peak_count,
  output logic [REG_W-1:0]    rms_volts,
  output logic                phase_ok,
  output logic                supply_ok
);

  logic                              out_v;
  logic                              load;
  logic [SAMPLE_W-1:0]               peak_z;
  logic [PROD_W-1:0]                 prod;
  logic [REG_W-1:0]                  rms;
  logic [REG_W-1:0]                  limit;
  logic                              ph_valid;
  logic                              ok;
  logic                              all_ok;
  logic [NUM_SRC-1:0][1:0]           pass_bits;

  assign eval_free = !out_v || out_ready;
  assign load      = win_valid && eval_free;

  assign peak_z = (win.peak < cfg.noise_floor) ? '0 : win.peak;
  assign prod   = PROD_W'(peak_z) * PROD_W'(RMS_MUL);
  assign rms    = prod[RMS_SHIFT +: REG_W];

  always_comb begin
    limit    = '0;
    ph_valid = 1'b1;
    unique case (win.phase)
      PHASE_R: limit = cfg.limit[win.source][0];
      PHASE_Y: limit = cfg.limit[win.source][1];
      PHASE_B: limit = cfg.limit[win.source][2];
      default: ph_valid = 1'b0;
    endcase
  end

  assign ok     = ph_valid && (rms >= limit);
  assign all_ok = (win.phase == PHASE_B) && ok && (pass_bits[win.source] == 2'b11);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v     <= 1'b0;
      pass_bits <= '0;
    end else begin
      if (eval_free) begin
        out_v <= win_valid;
      end
      // remember R and Y results; phase B and unused codes leave them alone
      if (load && (win.phase == PHASE_R)) begin
        pass_bits[win.source][0] <= ok;
      end
      if (load && (win.phase == PHASE_Y)) begin
        pass_bits[win.source][1] <= ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_source <= win.source;
      out_phase  <= win.phase;
      peak_count <= peak_z;
      rms_volts  <= rms;
      phase_ok   <= ok;
      supply_ok  <= all_ok;
    end
  end

  assign out_valid = out_v;

endmodule

/* rtl/core/three_phase_peak_voltage_monitor_unit.sv */
// ----------------------------------------------------------------------------
// three_phase_peak_voltage_monitor_unit
// Peak detector and RMS voltage check for three-phase mains / generator feeds.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ADC sample per transfer; tuser tags it with source
//   and phase, tlast marks the final sample of a window. Every sample feeds
//   one shared running maximum. A tlast transfer closes the window and yields
//   one m_axis transfer: peak after noise floor zeroing, RMS volts as
//   (peak*50690)>>16, the pass flag against that source/phase limit and, on
//   phase B, whether R, Y and B of that source all passed.
//   Samples without tlast produce no output.
// Path: a closing sample passes the input register, the window close
//   register and the result register before m_axis_tvalid rises.
// Throughput: one sample per cycle while s_axis_tready is high; the running
//   max is combinational and the evaluation stage has one 10x16 multiply.
// Stall: each stage advances when it is empty or when the next stage moves.
//   While the window close register is free, samples keep flowing even if a
//   result waits; s_axis_tready drops once the result and the window close
//   register are both held and the input register holds any sample.
// Reset: rst clears the stages, running peak, pass bits and restores the
//   register defaults (noise floor 10, all limits 180).
// cfg_we / cfg_index / cfg_data: write only while the block is idle.
// ----------------------------------------------------------------------------
module three_phase_peak_voltage_monitor_unit
  import pmon_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  // sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [9:0] sample, rest zero
  input  logic [2:0]           s_axis_tuser,   // [0] source, [2:1] phase
  input  logic                 s_axis_tlast,   // window_end
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // [9:0] peak_count, [19:10] rms_volts,
                                               // [20] phase_ok, [21] supply_ok, rest zero
  output logic [2:0]           m_axis_tuser    // [0] out_source, [2:1] out_phase
);

  cfg_t                cfg;
  logic                eval_free;
  logic                win_valid;
  win_t                win;
  logic                out_source;
  logic [PHASE_W-1:0]  out_phase;
  logic [SAMPLE_W-1:0] peak_count;
  logic [REG_W-1:0]    rms_volts;
  logic                phase_ok;
  logic                supply_ok;

  pmon_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Hold the sample, track the running maximum, capture closed windows
  pmon_peak u_peak (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_source (s_axis_tuser[0]),
    .in_phase  (s_axis_tuser[2:1]),
    .in_sample (s_axis_tdata[SAMPLE_W-1:0]),
    .in_last   (s_axis_tlast),
    .eval_free (eval_free),
    .win_valid (win_valid),
    .win       (win)
  );

  // Scale, check against the limit and register the result
  pmon_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .win_valid  (win_valid),
    .win        (win),
    .eval_free  (eval_free),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_source (out_source),
    .out_phase  (out_phase),
    .peak_count (peak_count),
    .rms_volts  (rms_volts),
    .phase_ok   (phase_ok),
    .supply_ok  (supply_ok)
  );

  assign m_axis_tdata = {2'b00, supply_ok, phase_ok, rms_volts, peak_count};
  assign m_axis_tuser = {out_phase, out_source};

endmodule
